FILE: hdl/kdcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kdcp_pkg;

    localparam int ROW_W  = 3;
    localparam int CODE_W = 4;
    localparam int BYTE_W = 8;
    localparam int LED_W  = 2;

    localparam logic [CODE_W-1:0] NO_KEY   = 4'd9;
    localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;
    localparam logic [BYTE_W-1:0] DEBOUNCE_RESET = 8'd5;

    localparam logic [CODE_W-1:0] KEY_POWER  = 4'd1;
    localparam logic [CODE_W-1:0] KEY_TIMER  = 4'd2;
    localparam logic [CODE_W-1:0] KEY_VOICE  = 4'd3;
    localparam logic [CODE_W-1:0] KEY_AMP_UP = 4'd4;
    localparam logic [CODE_W-1:0] KEY_AMP_DN = 4'd5;
    localparam logic [CODE_W-1:0] KEY_HEAT   = 4'd6;
    localparam logic [CODE_W-1:0] KEY_AUTO   = 4'd7;
    localparam logic [CODE_W-1:0] KEY_MANUAL = 4'd8;

    localparam logic [ROW_W-1:0] ROWS_IDLE = 3'd7;
    localparam logic [ROW_W-1:0] ROWS_R1   = 3'd3;
    localparam logic [ROW_W-1:0] ROWS_R2   = 3'd5;
    localparam logic [ROW_W-1:0] ROWS_R3   = 3'd6;

    typedef enum logic [LED_W-1:0] {
        LED_KEEP = 2'd0,
        LED_ON   = 2'd1,
        LED_OFF  = 2'd2
    } t_led_cmd;

    typedef struct packed {
        logic             tick;
        logic [ROW_W-1:0] rows_all;
        logic [ROW_W-1:0] rows_col_a;
        logic [ROW_W-1:0] rows_col_b;
        logic [ROW_W-1:0] rows_col_c;
        logic             sys_on;
        logic             auto_on;
        logic             timer_running;
    } t_scan_item;

    typedef struct packed {
        logic [BYTE_W-1:0] power_ctrl;
        logic [BYTE_W-1:0] level_ctrl;
        logic [BYTE_W-1:0] timer_setting;
        logic              key_accepted;
        logic [CODE_W-1:0] key_code;
        t_led_cmd          led_command;
    } t_result;

endpackage
`default_nettype wire

FILE: hdl/kdcp_decode.sv
`timescale 1ns / 1ps
`default_nettype none
module kdcp_decode (
    input  wire kdcp_pkg::t_scan_item     i_item,
    output logic [kdcp_pkg::CODE_W-1:0]   o_code
);

    logic [1:0] row;
    logic [1:0] col;
    logic       col_hit;

    always_comb begin
        unique case (i_item.rows_all)
            kdcp_pkg::ROWS_R1: row = 2'd1;
            kdcp_pkg::ROWS_R2: row = 2'd2;
            kdcp_pkg::ROWS_R3: row = 2'd3;
            default:           row = 2'd0;
        endcase
    end

    // last responding column wins
    always_comb begin
        col_hit = 1'b1;
        if (i_item.rows_col_c != kdcp_pkg::ROWS_IDLE) begin
            col = 2'd2;
        end else if (i_item.rows_col_b != kdcp_pkg::ROWS_IDLE) begin
            col = 2'd1;
        end else if (i_item.rows_col_a != kdcp_pkg::ROWS_IDLE) begin
            col = 2'd0;
        end else begin
            col     = 2'd0;
            col_hit = 1'b0;
        end
    end

    always_comb begin
        if (i_item.rows_all == kdcp_pkg::ROWS_IDLE || !col_hit || row == 2'd0) begin
            o_code = kdcp_pkg::NO_KEY;
        end else begin
            o_code = {2'b00, col} * 4'd3 + {2'b00, row};
        end
    end

endmodule
`default_nettype wire

FILE: hdl/kdcp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module kdcp_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [kdcp_pkg::BYTE_W-1:0]   i_cfg_wdata,
    input  wire                          i_adv,
    input  wire kdcp_pkg::t_scan_item    i_item,
    input  wire [kdcp_pkg::CODE_W-1:0]   i_code,
    output kdcp_pkg::t_result            o_result
);

    localparam logic [7:0] PWR_BIT   = 8'h80;
    localparam logic [7:0] VOICE_BIT = 8'h80;
    localparam logic [7:0] AUTO_BIT  = 8'h08;
    localparam logic [7:0] HEAT_STEP = 8'h10;
    localparam logic [7:0] HEAT_CLR  = 8'hcf;
    localparam logic [7:0] TIMER_MIN = 8'd15;
    localparam logic [7:0] TIMER_MAX = 8'd30;
    localparam logic [7:0] TIMER_INC = 8'd5;

    logic [7:0]                   r_debounce;
    logic [kdcp_pkg::CODE_W-1:0]  r_stable_code;
    logic                         r_change_pending;
    logic [7:0]                   r_chatter_count;
    logic [7:0]                   r_ctrl0;
    logic [7:0]                   r_ctrl1;
    logic [7:0]                   r_ctrl2;

    logic [kdcp_pkg::CODE_W-1:0]  n_stable_code;
    logic                         n_change_pending;
    logic [7:0]                   n_chatter_count;
    logic [7:0]                   n_ctrl0;
    logic [7:0]                   n_ctrl1;
    logic [7:0]                   n_ctrl2;

    logic                         pend;
    logic [7:0]                   cnt;
    logic                         accept;
    logic                         active;
    logic [7:0]                   timer_step;
    kdcp_pkg::t_led_cmd           led;

    always_comb begin
        n_stable_code    = r_stable_code;
        n_change_pending = r_change_pending;
        n_chatter_count  = r_chatter_count;
        n_ctrl0          = r_ctrl0;
        n_ctrl1          = r_ctrl1;
        n_ctrl2          = r_ctrl2;
        pend             = r_change_pending;
        cnt              = r_chatter_count;
        accept           = 1'b0;
        led              = kdcp_pkg::LED_KEEP;
        active           = i_item.sys_on && i_item.timer_running;
        timer_step       = r_ctrl2 + TIMER_INC;

        if (i_item.tick) begin
            if (i_code != r_stable_code) begin
                pend          = 1'b1;
                n_stable_code = i_code;
                cnt           = r_debounce;
            end
            if (pend && cnt == 8'd0) begin
                pend = 1'b0;
                if (n_stable_code != kdcp_pkg::NO_KEY) begin
                    accept = 1'b1;
                end
            end
            if (pend && cnt != 8'd0) begin
                cnt = cnt - 8'd1;
            end
            n_change_pending = pend;
            n_chatter_count  = cnt;
        end

        if (accept) begin
            unique case (n_stable_code)
                kdcp_pkg::KEY_POWER: begin
                    led     = kdcp_pkg::LED_ON;
                    n_ctrl0 = r_ctrl0 ^ PWR_BIT;
                end
                kdcp_pkg::KEY_TIMER: begin
                    if (i_item.sys_on) begin
                        n_ctrl2 = (timer_step > TIMER_MAX || timer_step < TIMER_MIN) ?
                                  TIMER_MIN : timer_step;
                    end
                end
                kdcp_pkg::KEY_VOICE: begin
                    led = kdcp_pkg::LED_OFF;
                    if (i_item.sys_on) begin
                        n_ctrl1 = r_ctrl1 ^ VOICE_BIT;
                    end
                end
                kdcp_pkg::KEY_AMP_UP: begin
                    if (active && r_ctrl1[3:0] != 4'hf) begin
                        n_ctrl1 = r_ctrl1 + 8'd1;
                    end
                end
                kdcp_pkg::KEY_AMP_DN: begin
                    if (active && r_ctrl1[3:0] != 4'h0) begin
                        n_ctrl1 = r_ctrl1 - 8'd1;
                    end
                end
                kdcp_pkg::KEY_HEAT: begin
                    if (active) begin
                        n_ctrl1 = (r_ctrl1[5:4] == 2'b11) ? (r_ctrl1 & HEAT_CLR) :
                                  (r_ctrl1 + HEAT_STEP);
                    end
                end
                kdcp_pkg::KEY_AUTO: begin
                    if (active) begin
                        n_ctrl0 = r_ctrl0 ^ AUTO_BIT;
                    end
                end
                kdcp_pkg::KEY_MANUAL: begin
                    if (active && !i_item.auto_on) begin
                        n_ctrl0 = (r_ctrl0[2:0] == 3'd6) ? {r_ctrl0[7:3], 3'd1} :
                                  (r_ctrl0 + 8'd1);
                    end
                end
                default: begin
                    led = kdcp_pkg::LED_KEEP;
                end
            endcase
        end

        o_result.power_ctrl    = n_ctrl0;
        o_result.level_ctrl    = n_ctrl1;
        o_result.timer_setting = n_ctrl2;
        o_result.key_accepted  = accept;
        o_result.key_code      = accept ? n_stable_code : kdcp_pkg::CODE_NONE;
        o_result.led_command   = led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce       <= kdcp_pkg::DEBOUNCE_RESET;
            r_stable_code    <= kdcp_pkg::CODE_NONE;
            r_change_pending <= 1'b0;
            r_chatter_count  <= 8'd0;
            r_ctrl0          <= 8'd0;
            r_ctrl1          <= 8'd0;
            r_ctrl2          <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_debounce <= i_cfg_wdata;
            end
            if (i_adv) begin
                r_stable_code    <= n_stable_code;
                r_change_pending <= n_change_pending;
                r_chatter_count  <= n_chatter_count;
                r_ctrl0          <= n_ctrl0;
                r_ctrl1          <= n_ctrl1;
                r_ctrl2          <= n_ctrl2;
            end
        end
    end

`ifndef SYNTH
    // count only runs while a change is pending
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_change_pending |-> r_chatter_count == 8'd0)
        else $error("chatter count nonzero with no pending change");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_ctrl0) && $stable(r_ctrl1) && $stable(r_ctrl2)
                   && $stable(r_stable_code))
        else $error("state moved without a request");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.key_accepted |-> o_result.key_code >= kdcp_pkg::KEY_POWER
                                  && o_result.key_code <= kdcp_pkg::KEY_MANUAL)
        else $error("accepted key out of range");

    a_led_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.led_command != kdcp_pkg::LED_KEEP |-> o_result.key_accepted)
        else $error("led command without accepted key");
`endif

endmodule
`default_nettype wire

FILE: hdl/keypad_debounce_control_panel_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | handshake                    | payload
// s_axis    | s_axis_tvalid/s_axis_tready  | tuser tick, tdata scan rows + status
// m_axis    | m_axis_tvalid/m_axis_tready  | tdata control bytes + key result
// cfg       | i_cfg_we                     | i_cfg_wdata debounce ticks
//
// One request per clock unless output stalls (input register, result register).
// Debounce state and control bytes update when a request leaves the input register.
// A stalled output holds its result; the input register still accepts while empty
// or draining. Synchronous active-low reset clears all control state.
module keypad_debounce_control_panel_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] rows_all, [5:3] rows_col_a, [8:6] rows_col_b, [11:9] rows_col_c,
    // [12] sys_on, [13] auto_on, [14] timer_running, [15] zero
    input  wire  [15:0] s_axis_tdata,
    // [0] tick
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] power_ctrl, [15:8] level_ctrl, [23:16] timer_setting,
    // [24] key_accepted, [28:25] key_code, [30:29] led_command, [31] zero
    output logic [31:0] m_axis_tdata
);

    logic                          r_s1_valid;
    kdcp_pkg::t_scan_item          r_s1_item;
    logic                          r_out_valid;
    logic [31:0]                   r_out_data;
    logic                          adv;
    logic [kdcp_pkg::CODE_W-1:0]   code;
    kdcp_pkg::t_result             result;

    assign adv           = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    kdcp_decode u_decode (
        .i_item (r_s1_item),
        .o_code (code)
    );

    kdcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .i_item      (r_s1_item),
        .i_code      (code),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_item.tick          <= s_axis_tuser;
            r_s1_item.rows_all      <= s_axis_tdata[2:0];
            r_s1_item.rows_col_a    <= s_axis_tdata[5:3];
            r_s1_item.rows_col_b    <= s_axis_tdata[8:6];
            r_s1_item.rows_col_c    <= s_axis_tdata[11:9];
            r_s1_item.sys_on        <= s_axis_tdata[12];
            r_s1_item.auto_on       <= s_axis_tdata[13];
            r_s1_item.timer_running <= s_axis_tdata[14];
        end
        if (adv) begin
            r_out_data <= {1'b0, result.led_command, result.key_code,
                           result.key_accepted, result.timer_setting,
                           result.level_ctrl, result.power_ctrl};
        end
    end

endmodule
`default_nettype wire
